>>> src/smih_pkg.sv
// Shared types, constants and hash step functions for the identifier-to-address hash unit.
package smih_pkg;

    typedef logic [2:0][31:0] t_hash_words;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_SHORT = 2'd1,
        STATUS_ALL_ZERO  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BMIX,
        ST_ADD,
        ST_FMIX,
        ST_DONE
    } t_back_state;

    typedef struct packed {
        logic [7:0] id_byte;
        logic [3:0] pos;
        logic       first;
        logic       mix;
        logic       last;
        logic [6:0] len;
        t_status    status;
    } t_byte_entry;

    localparam logic [1:0]  REG_ID_LENGTH  = 2'd0;
    localparam logic [1:0]  REG_MIN_LENGTH = 2'd1;
    localparam logic [6:0]  RESET_LENGTH   = 7'd16;
    localparam logic [3:0]  BLOCK_LAST_POS = 4'd11;
    localparam logic [2:0]  BMIX_LAST      = 3'd5;
    localparam logic [2:0]  FMIX_LAST      = 3'd6;
    localparam logic [31:0] INIT_FIRST     = 32'(64'hdeadbeef + 64'h35660001);
    localparam logic [31:0] INIT_SECOND    = 32'(64'hdeadbeef + 64'h35660002);

    function automatic logic [31:0] rotl(logic [31:0] v, int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // One row of the block mix per call.
    function automatic t_hash_words block_step(t_hash_words w, logic [2:0] k);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = w[0];
        b = w[1];
        c = w[2];
        unique case (k)
            3'd0: begin a = (a - c) ^ rotl(c, 4);  c = c + b; end
            3'd1: begin b = (b - a) ^ rotl(a, 6);  a = a + c; end
            3'd2: begin c = (c - b) ^ rotl(b, 8);  b = b + a; end
            3'd3: begin a = (a - c) ^ rotl(c, 16); c = c + b; end
            3'd4: begin b = (b - a) ^ rotl(a, 19); a = a + c; end
            3'd5: begin c = (c - b) ^ rotl(b, 4);  b = b + a; end
            default: ;
        endcase
        return {c, b, a};
    endfunction

    // One row of the final mix per call.
    function automatic t_hash_words final_step(t_hash_words w, logic [2:0] k);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = w[0];
        b = w[1];
        c = w[2];
        unique case (k)
            3'd0: c = (c ^ b) - rotl(b, 14);
            3'd1: a = (a ^ c) - rotl(c, 11);
            3'd2: b = (b ^ a) - rotl(a, 25);
            3'd3: c = (c ^ b) - rotl(b, 16);
            3'd4: a = (a ^ c) - rotl(c, 4);
            3'd5: b = (b ^ a) - rotl(a, 14);
            3'd6: c = (c ^ b) - rotl(b, 24);
            default: ;
        endcase
        return {c, b, a};
    endfunction

    // Load the initial value on the first byte, then add the byte at its lane.
    function automatic t_hash_words add_byte(t_hash_words w, logic [31:0] init_base,
                                             t_byte_entry e);
        t_hash_words r;
        logic [31:0] init;
        r = w;
        init = init_base + {25'd0, e.len};
        if (e.first) begin
            r = {init, init, init};
        end
        r[e.pos[3:2]] = r[e.pos[3:2]] + ({24'd0, e.id_byte} << {e.pos[1:0], 3'b000});
        return r;
    endfunction

    function automatic logic [47:0] build_mac(logic [31:0] h1, logic [31:0] h2);
        return {h1[7:2], 1'b1, 1'b0, h1[15:8], h1[23:16], h1[31:24], h2[7:0], h2[15:8]};
    endfunction

endpackage

>>> src/smih_fifo.sv
// Small register queue between the byte classifier and the hash engine.
module smih_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_din,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_dout,
    output logic             o_empty
);
    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr;
    logic [PtrW-1:0]  r_rd;
    logic [CntW-1:0]  r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CntFull);
    assign o_empty = (r_count == '0);
    assign o_dout  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PtrLast) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PtrLast) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

>>> src/smih_front.sv
// Front end: configuration registers, byte counting and per-byte classification.
module smih_front #(
    parameter int MAX_ID_BYTES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,
    input  logic                  i_cfg_valid,
    input  logic [1:0]            i_cfg_index,
    input  logic [6:0]            i_cfg_data,
    output logic                  o_push,
    output smih_pkg::t_byte_entry o_entry,
    input  logic                  i_full
);
    logic [6:0] r_id_length;
    logic [6:0] r_min_length;
    logic [6:0] r_count;
    logic [3:0] r_pos;
    logic [7:0] r_acc;
    logic [6:0] w_len;
    logic [7:0] w_acc;
    logic       w_cfg_hit;

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;
    assign w_acc      = r_acc | i_s_tdata;
    assign w_cfg_hit  = i_cfg_valid && (i_cfg_index == smih_pkg::REG_ID_LENGTH
                                        || i_cfg_index == smih_pkg::REG_MIN_LENGTH);

    always_comb begin
        w_len = r_id_length;
        if (w_len == 7'd0) begin
            w_len = 7'd1;
        end
        if (int'(w_len) > MAX_ID_BYTES) begin
            w_len = 7'(MAX_ID_BYTES);
        end
    end

    always_comb begin
        o_entry.id_byte = i_s_tdata;
        o_entry.pos     = r_pos;
        o_entry.first   = (r_count == 7'd0);
        o_entry.mix     = (r_count != 7'd0) && (r_pos == 4'd0);
        o_entry.last    = ((r_count + 7'd1) == w_len);
        o_entry.len     = w_len;
        priority if (w_len < r_min_length) begin
            o_entry.status = smih_pkg::STATUS_TOO_SHORT;
        end else if (w_acc == 8'd0) begin
            o_entry.status = smih_pkg::STATUS_ALL_ZERO;
        end else begin
            o_entry.status = smih_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_length  <= smih_pkg::RESET_LENGTH;
            r_min_length <= smih_pkg::RESET_LENGTH;
            r_count      <= '0;
            r_pos        <= '0;
            r_acc        <= '0;
        end else if (w_cfg_hit) begin
            if (i_cfg_index == smih_pkg::REG_ID_LENGTH) begin
                r_id_length <= i_cfg_data;
            end else begin
                r_min_length <= i_cfg_data;
            end
            // drop any partly received identifier
            r_count <= '0;
            r_pos   <= '0;
            r_acc   <= '0;
        end else if (o_push) begin
            if (o_entry.last) begin
                r_count <= '0;
                r_pos   <= '0;
                r_acc   <= '0;
            end else begin
                r_count <= r_count + 7'd1;
                r_pos   <= (r_pos == smih_pkg::BLOCK_LAST_POS) ? 4'd0 : r_pos + 4'd1;
                r_acc   <= w_acc;
            end
        end
    end
endmodule

>>> src/smih_back.sv
// Back end: two hash states, one mix row per cycle, and the result register.
module smih_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    output logic                  o_pop,
    input  smih_pkg::t_byte_entry i_entry,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [47:0]           o_m_tdata,
    output logic [1:0]            o_m_tuser
);
    smih_pkg::t_back_state r_state, n_state;
    smih_pkg::t_hash_words r_h1, n_h1;
    smih_pkg::t_hash_words r_h2, n_h2;
    smih_pkg::t_byte_entry r_entry, n_entry;
    logic [2:0]            r_step, n_step;
    logic                  r_out_valid, n_out_valid;
    logic [47:0]           r_mac, n_mac;
    logic [1:0]            r_status, n_status;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_mac;
    assign o_m_tuser  = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smih_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_h1        = r_h1;
        n_h2        = r_h2;
        n_entry     = r_entry;
        n_step      = r_step;
        n_mac       = r_mac;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_m_tready;
        o_pop       = 1'b0;
        unique case (r_state)
            smih_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_entry = i_entry;
                    n_step  = 3'd0;
                    if (i_entry.mix) begin
                        n_state = smih_pkg::ST_BMIX;
                    end else begin
                        n_h1 = smih_pkg::add_byte(r_h1, smih_pkg::INIT_FIRST, i_entry);
                        n_h2 = smih_pkg::add_byte(r_h2, smih_pkg::INIT_SECOND, i_entry);
                        if (i_entry.last) begin
                            n_state = smih_pkg::ST_FMIX;
                        end
                    end
                end
            end
            smih_pkg::ST_BMIX: begin
                n_h1 = smih_pkg::block_step(r_h1, r_step);
                n_h2 = smih_pkg::block_step(r_h2, r_step);
                if (r_step == smih_pkg::BMIX_LAST) begin
                    n_state = smih_pkg::ST_ADD;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            smih_pkg::ST_ADD: begin
                n_h1   = smih_pkg::add_byte(r_h1, smih_pkg::INIT_FIRST, r_entry);
                n_h2   = smih_pkg::add_byte(r_h2, smih_pkg::INIT_SECOND, r_entry);
                n_step = 3'd0;
                n_state = r_entry.last ? smih_pkg::ST_FMIX : smih_pkg::ST_IDLE;
            end
            smih_pkg::ST_FMIX: begin
                n_h1 = smih_pkg::final_step(r_h1, r_step);
                n_h2 = smih_pkg::final_step(r_h2, r_step);
                if (r_step == smih_pkg::FMIX_LAST) begin
                    n_state = smih_pkg::ST_DONE;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            smih_pkg::ST_DONE: begin
                // hold until the result register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_status    = r_entry.status;
                    n_mac       = (r_entry.status == smih_pkg::STATUS_OK)
                                  ? smih_pkg::build_mac(r_h1[2], r_h2[2]) : 48'd0;
                    n_state     = smih_pkg::ST_IDLE;
                end
            end
            default: n_state = smih_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h1     <= n_h1;
        r_h2     <= n_h2;
        r_entry  <= n_entry;
        r_mac    <= n_mac;
        r_status <= n_status;
    end
endmodule

>>> src/soc_id_mac_address_hash_unit.sv
// Top level: identifier bytes in, one station address and status out per identifier.
//
// Bytes stream in on the s side and are classified by a front end that counts them
// against the configured length; a four-entry queue feeds the hash engine, which keeps
// both hash states and applies one mix row per cycle. A byte that does not follow a
// full twelve-byte block is added directly; a byte that follows a full block first
// passes six block-mix rows and then the add, and the last byte is followed by seven
// final-mix rows and the load of the result register.
// The result waits in an output register while the next identifier streams in.
// Status on tuser is 0 for success, 1 for an identifier shorter than min_length and 2
// for an all-zero identifier; the address is zero whenever status is not 0. Register
// 0 is id_length and register 1 is min_length (both reset to 16); write them only
// while no identifier is in flight, since a write restarts the byte count.
module soc_id_mac_address_hash_unit #(
    parameter int MAX_ID_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] id_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,    // [47:0] mac_address
    output logic [1:0]  o_m_tuser,    // [1:0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    localparam int QueueDepth = 4;
    localparam int EntryW     = $bits(smih_pkg::t_byte_entry);

    smih_pkg::t_byte_entry w_push_entry;
    smih_pkg::t_byte_entry w_head_entry;
    logic                  w_push;
    logic                  w_full;
    logic                  w_pop;
    logic                  w_empty;

    assign o_cfg_ready = 1'b1;

    smih_front #(
        .MAX_ID_BYTES(MAX_ID_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (w_push),
        .o_entry     (w_push_entry),
        .i_full      (w_full)
    );

    smih_fifo #(
        .WIDTH(EntryW),
        .DEPTH(QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_din   (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_dout  (w_head_entry),
        .o_empty (w_empty)
    );

    smih_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .i_entry    (w_head_entry),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );
endmodule

>>> src/smih_checker.sv
// Port-level checks on the result stream of the hash unit, bound to the top level.
module smih_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);
    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                       && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != smih_pkg::STATUS_OK) |-> o_m_tdata == 48'd0)
        else $error("failed status with nonzero address");

    a_ok_local_unicast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == smih_pkg::STATUS_OK) |-> o_m_tdata[41:40] == 2'b10)
        else $error("address first byte flags wrong");
endmodule

bind soc_id_mac_address_hash_unit smih_checker u_checker (.*);
